// ----- hw/rtl/hex_or_base64_key_decoder_top_defines.svh -----
// Assertion macros used by the key decoder checker.
`ifndef HEX_OR_BASE64_KEY_DECODER_TOP_DEFINES_SVH
`define HEX_OR_BASE64_KEY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBKD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key decoder check failed");

`endif

// ----- hw/rtl/hbkd_pkg.sv -----
// Shared constants, types and character-class functions of the key decoder.
package hbkd_pkg;

  localparam int MAX_TEXT_CHARS = 64;
  localparam int MAX_KEY_BYTES  = 32;
  localparam int ADDR_W         = $clog2(MAX_TEXT_CHARS);
  localparam int CNT_W          = ADDR_W + 1;
  localparam int NB_W           = $clog2(MAX_TEXT_CHARS / 4 * 3 + 1);
  localparam int CAP_W          = 6;
  localparam int CAP_RESET      = 32;
  localparam int HEX_LEN_SHORT  = 2;
  localparam int HEX_LEN_MID    = 32;
  localparam int HEX_LEN_LONG   = 64;
  localparam int ACC_W          = 16;
  localparam int BITS_W         = 4;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  typedef struct packed {
    logic            reject;
    logic            empty;
    logic            hex_mode;
    logic [NB_W-1:0] n_bytes;
  } hbkd_verdict_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic hex_ok(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_digit(c)) begin
      t = c - 8'h30;
    end else if (c >= 8'h61) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  function automatic logic b64_ok(input logic [7:0] c);
    return is_upper(c) || is_lower(c) || is_digit(c) || (c == CHAR_PLUS) || (c == CHAR_SLASH);
  endfunction

  // Pad characters map to zero; their bits are never emitted.
  function automatic logic [5:0] b64_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_upper(c)) begin
      t = c - 8'h41;
    end else if (is_lower(c)) begin
      t = c - 8'h47;
    end else if (is_digit(c)) begin
      t = c + 8'h04;
    end else if (c == CHAR_PLUS) begin
      t = 8'd62;
    end else if (c == CHAR_SLASH) begin
      t = 8'd63;
    end else begin
      t = 8'd0;
    end
    return t[5:0];
  endfunction

endpackage

// ----- hw/rtl/hex_or_base64_key_decoder_top.sv -----
// Characters transfer in one per cycle; after the end-mark transfer the input stalls until
// the last result of the string is loaded into the output register.
// The verdict is taken the cycle after the end mark; a rejection or empty result then passes
// through the check and single-result states into the output register, waiting while the output stalls.
// Decoded bytes come from the store's single read port: each character is read and then
// appended to the bit accumulator, and each byte is sent in a step of its own.
// Synchronous active-low reset clears control and sets capacity to 32; store contents stay.
module hex_or_base64_key_decoder_top import hbkd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_code,
  input  logic             in_has_char,
  input  logic             in_end_of_text,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic             out_byte_valid,
  output logic             out_final_result,
  output logic             out_rejected,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  logic              in_xfer;
  logic              end_xfer;
  logic              busy;
  logic              clear;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  hbkd_verdict_t     verdict;

  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign end_xfer = in_xfer && in_end_of_text;

  hbkd_verdict u_verdict (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_xfer     (in_xfer),
    .char_code   (in_char_code),
    .has_char    (in_has_char),
    .clear       (clear),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .verdict     (verdict)
  );

  hbkd_text_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hbkd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .end_xfer         (end_xfer),
    .verdict          (verdict),
    .rd_data          (rd_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .clear            (clear),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_byte_valid   (out_byte_valid),
    .out_final_result (out_final_result),
    .out_rejected     (out_rejected)
  );

endmodule

// ----- hw/rtl/hbkd_text_ram.sv -----
// Character store: one write port, one read port with registered read data.
module hbkd_text_ram import hbkd_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MAX_TEXT_CHARS];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/hbkd_verdict.sv -----
// Load-side tracking of the string and the end-of-string verdict.
module hbkd_verdict import hbkd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_xfer,
  input  logic [7:0]        char_code,
  input  logic              has_char,
  input  logic              clear,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output hbkd_verdict_t     verdict
);

  logic [CNT_W-1:0]  count_r;
  logic              all_hex_r;
  logic              overflow_r;
  logic              b64_bad_r;
  logic              pad_seen_r;
  logic [ADDR_W-1:0] pad_pos_r;
  logic [CAP_W-1:0]  cap_r;

  logic              room;
  logic              store;
  logic              is_pad;
  logic [CAP_W-1:0]  lim_cap;
  logic [CNT_W-1:0]  limit;
  logic              hex_len;
  logic              hex_mode;
  logic [CNT_W-1:0]  grp;
  logic [CNT_W-1:0]  pads;
  logic [CNT_W-1:0]  b64_n;
  logic [CNT_W-1:0]  n_all;
  logic              b64_fail;

  assign room   = count_r < CNT_W'(MAX_TEXT_CHARS);
  assign store  = in_xfer && has_char && room;
  assign is_pad = char_code == CHAR_PAD;

  assign wr_en   = store;
  assign wr_addr = count_r[ADDR_W-1:0];
  assign wr_data = char_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r    <= '0;
      all_hex_r  <= 1'b1;
      overflow_r <= 1'b0;
      b64_bad_r  <= 1'b0;
      pad_seen_r <= 1'b0;
      pad_pos_r  <= '0;
    end else if (in_xfer && has_char) begin
      if (room) begin
        count_r <= count_r + CNT_W'(1);
        if (!hex_ok(char_code)) begin
          all_hex_r <= 1'b0;
        end
        // Any non-pad character after a pad, or one outside the alphabet, spoils base64
        if ((!is_pad && pad_seen_r) || (!is_pad && !b64_ok(char_code))) begin
          b64_bad_r <= 1'b1;
        end
        if (is_pad && !pad_seen_r) begin
          pad_seen_r <= 1'b1;
          pad_pos_r  <= count_r[ADDR_W-1:0];
        end
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

  assign lim_cap  = (cap_r < CAP_W'(MAX_KEY_BYTES)) ? cap_r : CAP_W'(MAX_KEY_BYTES);
  assign limit    = {{(CNT_W-CAP_W){1'b0}}, lim_cap};
  assign hex_len  = (count_r == CNT_W'(HEX_LEN_SHORT)) || (count_r == CNT_W'(HEX_LEN_MID)) ||
                    (count_r == CNT_W'(HEX_LEN_LONG));
  assign hex_mode = all_hex_r && hex_len;
  assign grp      = count_r >> 2;
  assign pads     = pad_seen_r ? (count_r - {1'b0, pad_pos_r}) : '0;
  assign b64_n    = (grp << 1) + grp - pads;
  assign n_all    = hex_mode ? (count_r >> 1) : b64_n;
  // Pads may start only in the last two places of the final group
  assign b64_fail = (count_r[1:0] != 2'b00) || b64_bad_r ||
                    (pad_seen_r && (({1'b0, pad_pos_r} + CNT_W'(2)) < count_r));

  always_comb begin
    verdict          = '0;
    verdict.empty    = (count_r == '0) && !overflow_r;
    verdict.hex_mode = hex_mode;
    verdict.n_bytes  = n_all[NB_W-1:0];
    verdict.reject   = overflow_r ||
                       ((count_r != '0) && ((!hex_mode && b64_fail) || (n_all > limit)));
  end

endmodule

// ----- hw/rtl/hbkd_emit.sv -----
// Sequencer that walks the store after the end mark and drives the result register.
module hbkd_emit import hbkd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              end_xfer,
  input  hbkd_verdict_t     verdict,
  input  logic [7:0]        rd_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              clear,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_data_byte,
  output logic              out_byte_valid,
  output logic              out_final_result,
  output logic              out_rejected
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SINGLE = 4'b0100,
    ST_EMIT   = 4'b1000
  } hbkd_state_t;

  hbkd_state_t       state_r, state_nxt;
  logic              hex_r, hex_nxt;
  logic              rej_r, rej_nxt;
  logic [NB_W-1:0]   n_r, n_nxt;
  logic [NB_W-1:0]   sent_r, sent_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              rd_pend_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_bvalid_r, out_bvalid_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_rej_r, out_rej_nxt;

  logic              slot_free;
  logic              rd_issue;
  logic              have_byte;
  logic              is_last;
  logic [BITS_W-1:0] top_bit;

  assign slot_free = !out_valid_r || !out_stall;
  assign have_byte = bits_r >= BITS_W'(8);
  assign rd_issue  = (state_r == ST_EMIT) && !rd_pend_r && !have_byte;
  assign is_last   = sent_r == (n_r - NB_W'(1));
  assign top_bit   = bits_r - BITS_W'(1);

  assign rd_en   = rd_issue;
  assign rd_addr = rd_ptr_r;
  assign clear   = state_r == ST_CHECK;
  assign busy    = state_r != ST_IDLE;

  always_comb begin
    state_nxt      = state_r;
    hex_nxt        = hex_r;
    rej_nxt        = rej_r;
    n_nxt          = n_r;
    sent_nxt       = sent_r;
    rd_ptr_nxt     = rd_ptr_r;
    acc_nxt        = acc_r;
    bits_nxt       = bits_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_bvalid_nxt = out_bvalid_r;
    out_final_nxt  = out_final_r;
    out_rej_nxt    = out_rej_r;

    case (state_r)
      ST_IDLE: begin
        if (end_xfer) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        hex_nxt    = verdict.hex_mode;
        rej_nxt    = verdict.reject;
        n_nxt      = verdict.n_bytes;
        sent_nxt   = '0;
        rd_ptr_nxt = '0;
        bits_nxt   = '0;
        state_nxt  = (verdict.reject || verdict.empty) ? ST_SINGLE : ST_EMIT;
      end
      ST_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_bvalid_nxt = 1'b0;
          out_final_nxt  = 1'b1;
          out_rej_nxt    = rej_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (rd_issue) begin
          rd_ptr_nxt = rd_ptr_r + ADDR_W'(1);
        end
        // Append the character fetched last cycle to the bit accumulator
        if (rd_pend_r) begin
          if (hex_r) begin
            acc_nxt  = {acc_r[ACC_W-5:0], hex_val(rd_data)};
            bits_nxt = bits_r + BITS_W'(4);
          end else begin
            acc_nxt  = {acc_r[ACC_W-7:0], b64_val(rd_data)};
            bits_nxt = bits_r + BITS_W'(6);
          end
        end else if (have_byte && slot_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = acc_r[top_bit -: 8];
          out_bvalid_nxt = 1'b1;
          out_final_nxt  = is_last;
          out_rej_nxt    = 1'b0;
          sent_nxt       = sent_r + NB_W'(1);
          bits_nxt       = bits_r - BITS_W'(8);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      bits_r      <= '0;
      sent_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_issue;
      out_valid_r <= out_valid_nxt;
      bits_r      <= bits_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hex_r        <= hex_nxt;
    rej_r        <= rej_nxt;
    n_r          <= n_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    acc_r        <= acc_nxt;
    out_data_r   <= out_data_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_final_r  <= out_final_nxt;
    out_rej_r    <= out_rej_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_byte_valid   = out_bvalid_r;
  assign out_final_result = out_final_r;
  assign out_rejected     = out_rej_r;

endmodule

// ----- hw/rtl/hbkd_checker.sv -----
// Port-level checks of the key decoder, bound to the top level.
`include "hex_or_base64_key_decoder_top_defines.svh"
module hbkd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_end_of_text,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_final_result,
  input logic       out_rejected
);

  // A rejection is a lone closing result carrying no byte
  `HBKD_ASSERT_NOW(a_rej_alone, out_valid && out_rejected, out_final_result && !out_byte_valid)

  // A result without a byte always closes the string
  `HBKD_ASSERT_NOW(a_nobyte_final, out_valid && !out_byte_valid, out_final_result)

  // The end-mark transfer holds off the next input item
  `HBKD_ASSERT_NEXT(a_end_stalls, in_valid && !in_stall && in_end_of_text, in_stall)

  // A stalled result holds
  `HBKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data_byte))

endmodule

bind hex_or_base64_key_decoder_top hbkd_checker u_hbkd_checker (.*);
